[sv/pms_pkg.sv]
// Shared types, constants and decode functions for the power-mode sequencer.
package pms_pkg;

    localparam int RAIL_COUNT = 12;
    localparam int RIDX_W     = $clog2(RAIL_COUNT);
    localparam int MASK_W     = 12;
    localparam int PRESS_W    = 16;
    localparam int TICKS_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;

    localparam logic [PRESS_W-1:0] LONG_PRESS_RESET  = PRESS_W'(3000);
    localparam logic [PRESS_W-1:0] SHORT_PRESS_RESET = PRESS_W'(100);
    localparam logic [TICKS_W-1:0] TICKS_MAX         = {TICKS_W{1'b1}};

    localparam int IRQ_BUTTON = 0;
    localparam int IRQ_PGOOD  = 1;
    localparam int IRQ_WAKE   = 2;

    localparam int WAKE_EN_USB = 1;
    localparam int WAKE_EN_CHG = 2;

    typedef enum logic [2:0] {
        PM_ACTIVE    = 3'd0,
        PM_IDLE      = 3'd1,
        PM_LIGHT     = 3'd2,
        PM_DEEP      = 3'd3,
        PM_HIBERNATE = 3'd4,
        PM_SHUTDOWN  = 3'd5
    } t_pmode;

    typedef enum logic [1:0] {
        K_TICK   = 2'd0,
        K_BUTTON = 2'd1,
        K_STATE  = 2'd2,
        K_RAIL   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        WAKE_NONE    = 3'd0,
        WAKE_BUTTON  = 3'd1,
        WAKE_USB     = 3'd2,
        WAKE_CHARGER = 3'd3,
        WAKE_TIMER   = 3'd4
    } t_wake;

    typedef enum logic [1:0] {
        CFG_WAKE_EN     = 2'd0,
        CFG_SLEEP_TICKS = 2'd1,
        CFG_LONG_PRESS  = 2'd2,
        CFG_SHORT_PRESS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_kind                kind;
        logic [PRESS_W-1:0]   press_ms;
        logic [2:0]           req_state;
        logic [3:0]           rail_sel;
        logic                 rail_on;
        logic                 usb_present;
        logic                 charger_present;
    } t_item;

    typedef struct packed {
        logic [2:0]           power_mode;
        logic [4:0]           pwr_ctl;
        logic [MASK_W-1:0]    rail_mask;
        logic [2:0]           irq_status;
        logic                 irq_pulse;
        logic [2:0]           wake_cause;
        logic                 rail_error;
    } t_result;

    typedef struct packed {
        logic                  valid;
        t_cfg_idx              index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    function automatic logic [4:0] ctl_code(t_pmode m);
        logic [4:0] c;
        unique case (m)
            PM_ACTIVE:    c = 5'h01;
            PM_IDLE:      c = 5'h02;
            PM_LIGHT:     c = 5'h04;
            PM_DEEP:      c = 5'h08;
            PM_HIBERNATE: c = 5'h10;
            default:      c = 5'h00;
        endcase
        return c;
    endfunction

    function automatic logic [MASK_W-1:0] mask_view(logic [RAIL_COUNT-1:0] m);
        logic [MASK_W-1:0] v;
        v = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < RAIL_COUNT) begin
                v[i] = m[i];
            end
        end
        return v;
    endfunction

endpackage

[sv/pms_in_reg.sv]
// Input register: unpacks and holds one accepted transaction until the core takes it.
module pms_in_reg
    import pms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [S_TDATA_W-1:0] i_tdata,
    input  logic [S_TUSER_W-1:0] i_tuser,
    input  logic                 i_take,
    output logic                 o_valid,
    output t_item                o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.kind            = t_kind'(i_tuser[1:0]);
        n_item.press_ms        = i_tdata[15:0];
        n_item.req_state       = i_tdata[18:16];
        n_item.rail_sel        = i_tdata[22:19];
        n_item.rail_on         = i_tdata[23];
        n_item.usb_present     = i_tdata[24];
        n_item.charger_present = i_tdata[25];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

[sv/pms_core.sv]
// Power state, rails, interrupts, wake cause, sleep timer and config registers.
module pms_core
    import pms_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg_wr i_cfg,
    output t_result o_result
);

    logic [2:0]            r_wake_en;
    logic [TICKS_W-1:0]    r_sleep_ticks;
    logic [PRESS_W-1:0]    r_long_press;
    logic [PRESS_W-1:0]    r_short_press;

    t_pmode                r_mode;
    logic [RAIL_COUNT-1:0] r_rails;
    logic [2:0]            r_irq;
    t_wake                 r_wake;
    logic [TICKS_W-1:0]    r_count;
    logic                  r_armed;

    t_pmode                n_mode;
    logic [RAIL_COUNT-1:0] n_rails;
    logic [2:0]            n_irq;
    t_wake                 n_wake;
    logic [TICKS_W-1:0]    n_count;
    logic                  n_armed;
    logic                  n_pulse;
    logic                  n_rerr;

    logic                  sleeping;
    logic                  timer_hit;
    logic                  do_wake;
    t_wake                 cause;

    always_comb begin
        n_mode    = r_mode;
        n_rails   = r_rails;
        n_irq     = r_irq;
        n_wake    = r_wake;
        n_count   = r_count;
        n_armed   = r_armed;
        n_pulse   = 1'b0;
        n_rerr    = 1'b0;
        sleeping  = (r_mode >= PM_LIGHT) && (r_mode <= PM_SHUTDOWN);
        timer_hit = 1'b0;
        do_wake   = 1'b0;
        cause     = WAKE_NONE;

        unique case (i_item.kind)
            K_TICK: begin
                if (r_count != TICKS_MAX) begin
                    n_count = r_count + TICKS_W'(1);
                end
                timer_hit = r_armed && (r_sleep_ticks != '0) && (n_count >= r_sleep_ticks);
                if (sleeping) begin
                    if (r_wake_en[WAKE_EN_USB] && i_item.usb_present) begin
                        do_wake = 1'b1;
                        cause   = WAKE_USB;
                    end else if (r_wake_en[WAKE_EN_CHG] && i_item.charger_present) begin
                        do_wake = 1'b1;
                        cause   = WAKE_CHARGER;
                    end else if (timer_hit) begin
                        do_wake = 1'b1;
                        cause   = WAKE_TIMER;
                    end
                    if (timer_hit) begin
                        n_armed = 1'b0;
                    end
                end
            end
            K_BUTTON: begin
                n_irq[IRQ_BUTTON] = 1'b1;
                n_pulse           = 1'b1;
                if (i_item.press_ms > r_long_press) begin
                    n_mode          = (r_mode == PM_SHUTDOWN) ? PM_ACTIVE : PM_SHUTDOWN;
                    n_irq[IRQ_PGOOD] = 1'b1;
                end else if (i_item.press_ms > r_short_press) begin
                    if (r_mode == PM_ACTIVE) begin
                        n_mode           = PM_LIGHT;
                        n_irq[IRQ_PGOOD] = 1'b1;
                    end else if (r_mode == PM_LIGHT) begin
                        do_wake = 1'b1;
                        cause   = WAKE_BUTTON;
                    end
                end
            end
            K_STATE: begin
                if ((i_item.req_state <= 3'(PM_SHUTDOWN)) &&
                    (i_item.req_state != 3'(r_mode))) begin
                    n_mode           = t_pmode'(i_item.req_state);
                    n_irq[IRQ_PGOOD] = 1'b1;
                    n_pulse          = 1'b1;
                    if (n_mode == PM_DEEP) begin
                        n_rails[7:5] = 3'b000;
                    end else if (n_mode == PM_HIBERNATE) begin
                        n_rails = r_rails & RAIL_COUNT'(2'b11);
                    end
                end
            end
            K_RAIL: begin
                if (int'(i_item.rail_sel) >= RAIL_COUNT) begin
                    n_rerr = 1'b1;
                end else begin
                    n_rails[i_item.rail_sel[RIDX_W-1:0]] = i_item.rail_on;
                end
            end
            default: ;
        endcase

        if (do_wake) begin
            n_mode           = PM_ACTIVE;
            n_rails          = '1;
            n_wake           = cause;
            n_irq[IRQ_PGOOD] = 1'b1;
            n_irq[IRQ_WAKE]  = 1'b1;
            n_pulse          = 1'b1;
        end

        o_result.power_mode    = 3'(n_mode);
        o_result.pwr_ctl       = ctl_code(n_mode);
        o_result.rail_mask     = mask_view(n_rails);
        o_result.irq_status    = n_irq;
        o_result.irq_pulse     = n_pulse;
        o_result.wake_cause    = 3'(n_wake);
        o_result.rail_error    = n_rerr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wake_en     <= '0;
            r_sleep_ticks <= '0;
            r_long_press  <= LONG_PRESS_RESET;
            r_short_press <= SHORT_PRESS_RESET;
            r_mode        <= PM_ACTIVE;
            r_rails       <= '1;
            r_irq         <= '0;
            r_wake        <= WAKE_NONE;
            r_count       <= '0;
            r_armed       <= 1'b1;
        end else begin
            if (i_fire) begin
                r_mode  <= n_mode;
                r_rails <= n_rails;
                r_irq   <= n_irq;
                r_wake  <= n_wake;
            end
            if (i_cfg.valid && (i_cfg.index == CFG_SLEEP_TICKS)) begin
                r_count <= '0;
                r_armed <= 1'b1;
            end else if (i_fire) begin
                r_count <= n_count;
                r_armed <= n_armed;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_WAKE_EN:     r_wake_en     <= i_cfg.data[2:0];
                    CFG_SLEEP_TICKS: r_sleep_ticks <= i_cfg.data[TICKS_W-1:0];
                    CFG_LONG_PRESS:  r_long_press  <= i_cfg.data[PRESS_W-1:0];
                    CFG_SHORT_PRESS: r_short_press <= i_cfg.data[PRESS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[sv/power_mode_sequencer_top.sv]
// Top level of the power-mode sequencer: input register, core and result register.
//
//  channel   direction  signals                        payload
//  s_axis    in         tvalid tready tdata tuser      one event (tick, press, request, rail)
//  m_axis    out        tvalid tready tdata            status after that event
//  cfg       in         valid ready index data         register write, always ready
//
// One transaction per cycle while m_axis does not stall; an s_axis transaction is held in the input register,
// its result is then loaded into the result register and offered on m_axis from there.
// All decisions are one level of logic between the input register and the result register.
// Reset (i_rst_n low, synchronous) restores the registers to their reset values.
// While m_axis stalls, one more transaction waits in the input register, then s_axis stalls.
module power_mode_sequencer_top
    import pms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [15:0] press_ms, [18:16] req_state, [22:19] rail_sel, [23] rail_on,
    // [24] usb_present, [25] charger_present, [31:26] zero
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] kind (tick, button, state request, rail)
    input  logic [S_TUSER_W-1:0]  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [2:0] power_mode, [7:3] pwr_ctl, [19:8] rail_mask, [22:20] irq_status,
    // [23] irq_pulse, [26:24] wake_cause, [27] rail_error, [31:28] zero
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic    in_valid;
    t_item   in_item;
    logic    fire;
    t_result core_res;
    t_cfg_wr cfg_wr;

    logic    r_out_valid;
    t_result r_out;

    assign fire        = in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cfg_wr.valid = i_cfg_valid;
        cfg_wr.index = t_cfg_idx'(i_cfg_index);
        cfg_wr.data  = i_cfg_data;
    end

    pms_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_tdata (i_s_axis_tdata),
        .i_tuser (i_s_axis_tuser),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    pms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (in_item),
        .i_cfg    (cfg_wr),
        .o_result (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.rail_error, r_out.wake_cause, r_out.irq_pulse,
                              r_out.irq_status, r_out.rail_mask, r_out.pwr_ctl,
                              r_out.power_mode};

endmodule

[sv/pms_checker.sv]
// Port-level checker for the power-mode sequencer, bound to the top level.
module pms_checker
    import pms_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [M_TDATA_W-1:0]  o_m_axis_tdata
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_ctl_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ((o_m_axis_tdata[2:0] == 3'(PM_SHUTDOWN)) && (o_m_axis_tdata[7:3] == 5'd0)) ||
            ((o_m_axis_tdata[2:0] <= 3'(PM_HIBERNATE)) &&
             (o_m_axis_tdata[7:3] == (5'd1 << o_m_axis_tdata[2:0]))))
        else $error("power control does not match power mode");

    a_rail_err_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[27] |-> !o_m_axis_tdata[23])
        else $error("rail error with interrupt pulse");

    a_pulse_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[23] |-> (o_m_axis_tdata[22:20] != 3'd0))
        else $error("interrupt pulse without status bit");

endmodule

bind power_mode_sequencer_top pms_checker u_pms_checker (.*);
